/* hdl/fas_pkg.sv */
`default_nettype none
package fas_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    // Frame positions and table indexes are 6 bits wide, so 64 is the hard ceiling.
    localparam int FRAME_LIM      = 64;
    localparam int FRAME_W        = 6;
    localparam int COUNT_W        = 7;
    localparam int TIME_W         = 24;
    localparam int SPEED_W        = 16;
    localparam int TIMER_W        = 32;
    localparam int SPEED_FRAC     = 12;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 7'd1;
    localparam logic [SPEED_W-1:0] SPEED_ONE       = 16'd4096;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_PLAY      = 3'd1,
        OP_STOP      = 3'd2,
        OP_PAUSE     = 3'd3,
        OP_RESUME    = 3'd4,
        OP_WRITE_DUR = 3'd5,
        OP_RESET_ANI = 3'd6,
        OP_NONE      = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_LOOP     = 2'd0,
        MODE_ONCE     = 2'd1,
        MODE_PINGPONG = 2'd2,
        MODE_BAD      = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 2'd0,
        CFG_PLAY_MODE   = 2'd1,
        CFG_SPEED       = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [TIME_W-1:0] delta_time;
        logic [5:0]        table_index;
        logic [TIME_W-1:0] frame_duration;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0] current_frame;
        logic               frame_changed;
        logic [FRAME_W-1:0] departed_frame;
        logic               completed;
        logic               playing;
        logic               paused;
    } t_out_item;

endpackage
`default_nettype wire

/* hdl/fas_channels.sv */
`default_nettype none
interface fas_in_if;
    import fas_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fas_out_if;
    import fas_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/frame_animation_sequencer.sv */
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    opcode, delta_time, table_index, frame_duration
// o_out    out  valid/ready    current_frame, frame_changed, departed_frame,
//                              completed, playing, paused
// i_cfg    in   we only        frame_count, play_mode, speed (by index)
//
// One item per cycle while i_in.ready is high; its result is valid the
// cycle after it is accepted. The duration of the current frame is
// prefetched from the table RAM, so a tick does multiply, add, compare
// and subtract in the accepting cycle. i_in.ready is low in reset, else
// high while the result register is empty or being taken.
// Synchronous active-low reset; the duration table is not cleared.
`default_nettype none
module frame_animation_sequencer #(
    parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fas_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fas_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    fas_in_if.sink                             i_in,
    fas_out_if.source                          o_out
);
    import fas_pkg::*;

    localparam int TAB_DEPTH = (MAX_FRAMES < FRAME_LIM) ? MAX_FRAMES : FRAME_LIM;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam logic [COUNT_W-1:0] LIM_CNT = COUNT_W'(TAB_DEPTH);

    logic [COUNT_W-1:0] r_frame_count;
    logic [1:0]         r_play_mode;
    logic [SPEED_W-1:0] r_speed;

    logic [FRAME_W-1:0] r_pos, n_pos;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_playing, n_playing;
    logic               r_paused, n_paused;
    logic               r_fwd, n_fwd;

    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic               r_byp_hit;
    logic [TIME_W-1:0]  r_byp_data;
    logic [TIME_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]  cur_dur;

    logic               accept;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr;
    logic [TAB_AW-1:0]  tab_raddr;

    logic [COUNT_W-1:0] eff_cnt;
    logic [COUNT_W-1:0] pos_inc;
    logic               has_next;
    logic [39:0]        prod;
    logic [27:0]        scaled;
    logic [TIMER_W:0]   sum;
    logic [TIMER_W-1:0] sum_sat;
    logic               due;
    t_in_item           item;

    assign item     = i_in.data;
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_play_mode   <= MODE_LOOP;
            r_speed       <= SPEED_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_wdata[COUNT_W-1:0];
                CFG_PLAY_MODE:   r_play_mode   <= i_cfg_wdata[1:0];
                CFG_SPEED:       r_speed       <= i_cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Duration table; read address follows the next frame position.
    assign tab_we    = accept && (t_opcode'(item.opcode) == OP_WRITE_DUR)
                       && (32'(item.table_index) < MAX_FRAMES);
    assign tab_waddr = TAB_AW'(item.table_index);
    assign tab_raddr = i_rst_n ? n_pos[TAB_AW-1:0] : '0;

    fas_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TAB_DEPTH)
    ) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (item.frame_duration),
        .i_raddr (tab_raddr),
        .o_rdata (ram_rdata)
    );

    // Forward a write that lands on the prefetched entry.
    always_ff @(posedge i_clk) begin
        r_byp_hit  <= tab_we && (tab_waddr == tab_raddr);
        r_byp_data <= item.frame_duration;
    end

    assign cur_dur = r_byp_hit ? r_byp_data : ram_rdata;

    always_comb begin
        if (r_frame_count == '0) begin
            eff_cnt = COUNT_W'(1);
        end else if (r_frame_count > LIM_CNT) begin
            eff_cnt = LIM_CNT;
        end else begin
            eff_cnt = r_frame_count;
        end
    end

    assign pos_inc  = COUNT_W'(r_pos) + COUNT_W'(1);
    assign has_next = pos_inc < eff_cnt;

    assign prod    = {16'b0, item.delta_time} * {24'b0, r_speed};
    assign scaled  = prod[39:SPEED_FRAC];
    assign sum     = {1'b0, r_timer} + (TIMER_W+1)'(scaled);
    assign sum_sat = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
    assign due     = sum_sat >= TIMER_W'(cur_dur);

    always_comb begin
        n_pos     = r_pos;
        n_timer   = r_timer;
        n_playing = r_playing;
        n_paused  = r_paused;
        n_fwd     = r_fwd;
        n_out     = '0;
        if (accept) begin
            unique case (t_opcode'(item.opcode))
                OP_TICK: begin
                    if (r_playing && !r_paused) begin
                        n_timer = sum_sat;
                        if (due) begin
                            n_timer = sum_sat - TIMER_W'(cur_dur);
                            n_out.frame_changed  = 1'b1;
                            n_out.departed_frame = r_pos;
                            unique case (t_mode'(r_play_mode))
                                MODE_ONCE: begin
                                    if (has_next) begin
                                        n_pos = pos_inc[FRAME_W-1:0];
                                    end else begin
                                        // finish: halt and flag completion
                                        n_playing = 1'b0;
                                        n_paused  = 1'b0;
                                        n_pos     = '0;
                                        n_timer   = '0;
                                        n_out.completed = 1'b1;
                                    end
                                end
                                MODE_PINGPONG: begin
                                    if (r_fwd) begin
                                        if (has_next) begin
                                            n_pos = pos_inc[FRAME_W-1:0];
                                        end else begin
                                            n_fwd = 1'b0;
                                            n_pos = (eff_cnt >= COUNT_W'(2))
                                                  ? FRAME_W'(eff_cnt - COUNT_W'(2)) : '0;
                                        end
                                    end else begin
                                        if (r_pos != '0) begin
                                            n_pos = r_pos - FRAME_W'(1);
                                        end else begin
                                            n_fwd = 1'b1;
                                            n_pos = (eff_cnt >= COUNT_W'(2))
                                                  ? FRAME_W'(1) : '0;
                                        end
                                    end
                                end
                                default: begin
                                    // loop, and the unused mode code
                                    n_pos = has_next ? pos_inc[FRAME_W-1:0] : '0;
                                end
                            endcase
                        end
                    end
                end
                OP_PLAY: begin
                    n_pos     = '0;
                    n_timer   = '0;
                    n_playing = 1'b1;
                    n_paused  = 1'b0;
                    n_fwd     = 1'b1;
                end
                OP_STOP: begin
                    n_pos     = '0;
                    n_timer   = '0;
                    n_playing = 1'b0;
                    n_paused  = 1'b0;
                end
                OP_PAUSE: begin
                    if (r_playing) begin
                        n_paused = 1'b1;
                    end
                end
                OP_RESUME: begin
                    n_paused = 1'b0;
                end
                OP_RESET_ANI: begin
                    n_pos   = '0;
                    n_timer = '0;
                end
                default: ;
            endcase
        end
        n_out.current_frame = n_pos;
        n_out.playing       = n_playing;
        n_out.paused        = n_paused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_timer     <= '0;
            r_playing   <= 1'b0;
            r_paused    <= 1'b0;
            r_fwd       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_timer   <= n_timer;
            r_playing <= n_playing;
            r_paused  <= n_paused;
            r_fwd     <= n_fwd;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < TAB_DEPTH)
        else $error("frame position outside the duration table");

    a_pause_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_paused |-> r_playing)
        else $error("paused while not playing");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_completed_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.completed) |->
            (r_out.frame_changed && !r_out.playing && r_out.current_frame == '0))
        else $error("completion without halt");

    a_no_change_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !(r_playing && !r_paused)) |=> !r_out.frame_changed)
        else $error("frame advanced while idle");
endmodule
`default_nettype wire

/* hdl/fas_ram.sv */
`default_nettype none
module fas_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
